/* rtl/lct_pkg.sv */
// Shared types and constants for the LFU tag table.
`default_nettype none

package lct_pkg;

  // Field widths of one word on each side.
  localparam int KEY_W   = 64;
  localparam int LEN_W   = 32;
  localparam int USE_W   = 32;
  localparam int CNT_W   = 8;
  localparam int IDX_O_W = 7;

  // Capacity register value after reset.
  localparam logic [CNT_W-1:0] CAP_RST = 8'd128;

  // A use count stops counting at this value.
  localparam logic [USE_W-1:0] USE_MAX = 32'hFFFF_FFFF;

  // Operation carried by a command word.
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [USE_W-1:0] cnt;
  } entry_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic             clr;
    logic             vld;
    logic             find_min;
    logic [CNT_W-1:0] idx;
  } cmp_ctl_t;

  // Status from the compare unit back to the sequencer.
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] best_idx;
    entry_t           ent;
  } cmp_stat_t;

endpackage

`default_nettype wire

/* rtl/lct_mem.sv */
// Entry storage: one write port and one registered read port.
`default_nettype none

module lct_mem #(
  parameter int ENTRIES = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(ENTRIES)-1:0]    waddr_i,
  input  wire lct_pkg::entry_t               wdata_i,
  input  wire logic                          re_i,
  input  wire logic [$clog2(ENTRIES)-1:0]    raddr_i,
  output lct_pkg::entry_t                    rdata_o
);

  lct_pkg::entry_t mem_q [ENTRIES];
  lct_pkg::entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with the data registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/lct_cmp.sv */
// Shared compare unit: key match for lookups, smallest use count for eviction.
`default_nettype none

module lct_cmp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lct_pkg::cmp_ctl_t             ctl_i,
  input  wire logic [lct_pkg::KEY_W-1:0]     key_i,
  input  wire lct_pkg::entry_t               ent_i,
  output lct_pkg::cmp_stat_t                 stat_o
);

  logic                          found_q, found_d;
  logic [lct_pkg::CNT_W-1:0]     best_idx_q, best_idx_d;
  logic [lct_pkg::USE_W-1:0]     best_cnt_q, best_cnt_d;
  lct_pkg::entry_t               ent_q, ent_d;

  // One entry is judged per cycle while vld is high. A lookup keeps the first match; the
  // eviction search keeps the first entry with a strictly smaller count.
  always_comb begin
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    ent_d      = ent_q;
    if (ctl_i.clr) begin
      found_d = 1'b0;
    end else if (ctl_i.vld) begin
      if (ctl_i.find_min) begin
        if (!found_q || (ent_i.cnt < best_cnt_q)) begin
          found_d    = 1'b1;
          best_idx_d = ctl_i.idx;
          best_cnt_d = ent_i.cnt;
        end
      end else if (!found_q && (ent_i.key == key_i)) begin
        found_d    = 1'b1;
        best_idx_d = ctl_i.idx;
        ent_d      = ent_i;
      end
    end
  end

  // Only the found flag is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  // Best candidate so far.
  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
    ent_q      <= ent_d;
  end

  assign stat_o.found    = found_q;
  assign stat_o.best_idx = best_idx_q;
  assign stat_o.ent      = ent_q;

endmodule

`default_nettype wire

/* rtl/lfu_cache_tag_table_core.sv */
// Top level of the LFU tag table: sequencer, capacity register and result word.
//
// A fully associative tag table with least-frequently-used replacement. A
// command word is taken when start is high and busy is low. A lookup walks
// the filled entries in use, one entry per cycle through a single registered
// read port of the entry memory and one shared compare unit, and stops at the
// first match. An insert into a table that is not yet full is answered in the
// cycle after it is taken. An insert into a full table scans all entries in
// use for the smallest use count. The result word is shown for exactly one
// cycle with done_o high and cannot be held off, so it must be captured when
// it appears. The capacity register is written through its own channel, which
// is always ready; write it only while the table is idle. No clearing pass
// follows reset: entries are read only after they have been written.
`default_nettype none

module lfu_cache_tag_table_core #(
  parameter int ENTRIES = 128
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Command channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             op_i,
  input  wire logic [lct_pkg::KEY_W-1:0]        key_i,
  input  wire logic [lct_pkg::LEN_W-1:0]        item_length_i,
  // Result word
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic [lct_pkg::IDX_O_W-1:0]           entry_index_o,
  output logic [lct_pkg::LEN_W-1:0]             stored_length_o,
  output logic                                  evicted_o,
  // Capacity register write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [lct_pkg::CNT_W-1:0]        cfg_data_i
);

  localparam int AW      = $clog2(ENTRIES);
  localparam int CAP_MAX = (ENTRIES < 255) ? ENTRIES : 255;
  localparam logic [lct_pkg::CNT_W-1:0] CAP_MAX_C = lct_pkg::CNT_W'(CAP_MAX);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } st_e;

  st_e                          state_q;
  logic [lct_pkg::CNT_W-1:0]    cap_q;
  logic [lct_pkg::CNT_W-1:0]    filled_q;
  logic [lct_pkg::CNT_W-1:0]    rd_cnt_q;
  logic [lct_pkg::CNT_W-1:0]    limit_q;
  logic                         p_vld_q;
  logic [lct_pkg::CNT_W-1:0]    p_idx_q;
  logic                         done_q;
  logic                         hit_q;
  logic [lct_pkg::IDX_O_W-1:0]  idx_q;
  logic [lct_pkg::LEN_W-1:0]    len_out_q;
  logic                         evicted_q;

  // Command held for the length of the scan.
  logic                         op_q;
  logic [lct_pkg::KEY_W-1:0]    key_q;
  logic [lct_pkg::LEN_W-1:0]    len_q;

  logic [lct_pkg::CNT_W-1:0]    cap_live;
  logic [lct_pkg::CNT_W-1:0]    span;
  logic                         accept;
  logic                         ins_free;
  logic                         lookup_hit;
  logic                         scan_end;
  logic                         re;
  logic                         we;
  logic [AW-1:0]                waddr;
  lct_pkg::entry_t              wdata;
  lct_pkg::entry_t              rdata;
  lct_pkg::cmp_ctl_t            ctl;
  lct_pkg::cmp_stat_t           stat;

  // Capacity in effect: zero acts as one, and it never exceeds the table.
  always_comb begin
    cap_live = cap_q;
    if (cap_q == '0) begin
      cap_live = lct_pkg::CNT_W'(1);
    end else if (cap_q > CAP_MAX_C) begin
      cap_live = CAP_MAX_C;
    end
  end

  assign span       = (filled_q < cap_live) ? filled_q : cap_live;
  assign accept     = start && (state_q == ST_IDLE);
  assign ins_free   = (op_i == lct_pkg::OP_INSERT) && (filled_q < cap_live);
  assign lookup_hit = (state_q == ST_SCAN) && (op_q == lct_pkg::OP_LOOKUP) && stat.found;
  assign scan_end   = (state_q == ST_SCAN) && (rd_cnt_q == limit_q) && !p_vld_q;
  assign re         = (state_q == ST_SCAN) && (rd_cnt_q != limit_q) && !lookup_hit;

  // Memory write: a fresh insert, an eviction, or a use count bump on a hit.
  always_comb begin
    we    = 1'b0;
    waddr = AW'(stat.best_idx);
    wdata = '{key: key_q, len: len_q, cnt: '0};
    if (accept) begin
      we    = ins_free;
      waddr = AW'(filled_q);
      wdata = '{key: key_i, len: item_length_i, cnt: '0};
    end else if (lookup_hit) begin
      we    = 1'b1;
      wdata = stat.ent;
      if (stat.ent.cnt != lct_pkg::USE_MAX) begin
        wdata.cnt = stat.ent.cnt + lct_pkg::USE_W'(1);
      end
    end else if (scan_end && (op_q == lct_pkg::OP_INSERT)) begin
      we = 1'b1;
    end
  end

  // Compare unit control.
  assign ctl.clr      = accept;
  assign ctl.vld      = p_vld_q;
  assign ctl.find_min = (op_q == lct_pkg::OP_INSERT);
  assign ctl.idx      = p_idx_q;

  lct_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (AW'(rd_cnt_q)),
    .rdata_o (rdata)
  );

  lct_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .key_i  (key_q),
    .ent_i  (rdata),
    .stat_o (stat)
  );

  // Sequencer, capacity register and result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= lct_pkg::CAP_RST;
      filled_q  <= '0;
      rd_cnt_q  <= '0;
      limit_q   <= '0;
      p_vld_q   <= 1'b0;
      done_q    <= 1'b0;
      hit_q     <= 1'b0;
      idx_q     <= '0;
      len_out_q <= '0;
      evicted_q <= 1'b0;
    end else begin
      done_q  <= 1'b0;
      p_vld_q <= re;
      if (re) begin
        rd_cnt_q <= rd_cnt_q + lct_pkg::CNT_W'(1);
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (ins_free) begin
              filled_q  <= filled_q + lct_pkg::CNT_W'(1);
              done_q    <= 1'b1;
              hit_q     <= 1'b0;
              idx_q     <= filled_q[lct_pkg::IDX_O_W-1:0];
              len_out_q <= item_length_i;
              evicted_q <= 1'b0;
            end else begin
              state_q  <= ST_SCAN;
              rd_cnt_q <= '0;
              limit_q  <= (op_i == lct_pkg::OP_INSERT) ? cap_live : span;
            end
          end
        end
        ST_SCAN: begin
          if (lookup_hit) begin
            state_q   <= ST_IDLE;
            done_q    <= 1'b1;
            hit_q     <= 1'b1;
            idx_q     <= stat.best_idx[lct_pkg::IDX_O_W-1:0];
            len_out_q <= stat.ent.len;
            evicted_q <= 1'b0;
          end else if (scan_end) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            hit_q   <= 1'b0;
            if (op_q == lct_pkg::OP_INSERT) begin
              idx_q     <= stat.best_idx[lct_pkg::IDX_O_W-1:0];
              len_out_q <= len_q;
              evicted_q <= 1'b1;
            end else begin
              idx_q     <= '0;
              len_out_q <= '0;
              evicted_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Command capture and read pipeline index.
  always_ff @(posedge clk_i) begin
    p_idx_q <= rd_cnt_q;
    if (accept) begin
      op_q  <= op_i;
      key_q <= key_i;
      len_q <= item_length_i;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign entry_index_o   = idx_q;
  assign stored_length_o = len_out_q;
  assign evicted_o       = evicted_q;

  // The result word only appears as the table goes idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word shown while the table is busy");

  // The fill count never passes the largest usable capacity.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CAP_MAX_C)
    else $error("fill count beyond table capacity");

  // An insert into a table with room answers on the next cycle.
  a_fast_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ins_free) |=> (done_o && !hit_o && !evicted_o))
    else $error("insert into free entry did not complete in one cycle");

  // A hit and an eviction never come together.
  a_hit_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o))
    else $error("result marks both hit and eviction");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the LFU tag table: directed and random command words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = 128;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  // One result word as the table should report it.
  typedef struct packed {
    logic                        hit;
    logic [lct_pkg::IDX_O_W-1:0] idx;
    logic [lct_pkg::LEN_W-1:0]   len;
    logic                        evicted;
  } tag_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        op_i = lct_pkg::OP_LOOKUP;
  logic [lct_pkg::KEY_W-1:0]   key_i = '0;
  logic [lct_pkg::LEN_W-1:0]   item_length_i = '0;
  logic                        done_o;
  logic                        hit_o;
  logic [lct_pkg::IDX_O_W-1:0] entry_index_o;
  logic [lct_pkg::LEN_W-1:0]   stored_length_o;
  logic                        evicted_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [lct_pkg::CNT_W-1:0]   cfg_data_i = '0;

  // Shadow copy of the table and the capacity register.
  logic [lct_pkg::KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [lct_pkg::LEN_W-1:0] shadow_lens [TABLE_DEPTH];
  logic [lct_pkg::USE_W-1:0] shadow_uses [TABLE_DEPTH];
  int                        shadow_filled = 0;
  logic [lct_pkg::CNT_W-1:0] shadow_capacity = lct_pkg::CAP_RST;

  tag_result_t expected_words[$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          stall_cycles = 0;

  lfu_cache_tag_table_core #(
    .ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .key_i          (key_i),
    .item_length_i  (item_length_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .entry_index_o  (entry_index_o),
    .stored_length_o(stored_length_o),
    .evicted_o      (evicted_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Capacity as the table applies it: zero acts as one, large values as the depth.
  function automatic int live_capacity();
    int c;
    c = int'(shadow_capacity);
    if (c == 0) c = 1;
    if (c > TABLE_DEPTH) c = TABLE_DEPTH;
    return c;
  endfunction

  // Apply one command word to the shadow table and return the result it should give.
  function automatic tag_result_t predict_result(lct_pkg::op_e op,
                                                 logic [lct_pkg::KEY_W-1:0] key,
                                                 logic [lct_pkg::LEN_W-1:0] len);
    tag_result_t               res;
    int                        cap;
    int                        span;
    int                        slot;
    logic [lct_pkg::USE_W-1:0] least;
    res = '0;
    cap = live_capacity();
    if (op == lct_pkg::OP_LOOKUP) begin
      span = (shadow_filled < cap) ? shadow_filled : cap;
      for (int i = 0; i < span; i++) begin
        if (shadow_keys[i] == key) begin
          if (shadow_uses[i] != lct_pkg::USE_MAX) shadow_uses[i] = shadow_uses[i] + 1;
          res.hit = 1'b1;
          res.idx = i[lct_pkg::IDX_O_W-1:0];
          res.len = shadow_lens[i];
          break;
        end
      end
    end else begin
      if (shadow_filled < cap) begin
        slot = shadow_filled;
        shadow_filled++;
      end else begin
        // Least used entry among those in use; ties go to the lowest index.
        least = shadow_uses[0];
        slot = 0;
        for (int i = 1; i < cap; i++) begin
          if (shadow_uses[i] < least) begin
            least = shadow_uses[i];
            slot = i;
          end
        end
        res.evicted = 1'b1;
      end
      shadow_keys[slot] = key;
      shadow_lens[slot] = len;
      shadow_uses[slot] = '0;
      res.idx = slot[lct_pkg::IDX_O_W-1:0];
      res.len = len;
    end
    return res;
  endfunction

  // Send one command word; start stays high afterwards unless the next call idles.
  task automatic send_word(lct_pkg::op_e op, logic [lct_pkg::KEY_W-1:0] key,
                           logic [lct_pkg::LEN_W-1:0] len);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    key_i <= key;
    item_length_i <= len;
    do @(posedge clk_i); while (busy);
    expected_words.push_back(predict_result(op, key, len));
  endtask

  // Write the capacity register once the table has delivered everything.
  task automatic write_capacity(logic [lct_pkg::CNT_W-1:0] value);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_capacity = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [lct_pkg::LEN_W-1:0] want,
                               logic [lct_pkg::LEN_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Each result word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    tag_result_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $display("%0t ns: result word with none expected, index %0h", $time, entry_index_o);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        compare_field("hit", lct_pkg::LEN_W'(want.hit), lct_pkg::LEN_W'(hit_o));
        compare_field("entry_index", lct_pkg::LEN_W'(want.idx),
                      lct_pkg::LEN_W'(entry_index_o));
        compare_field("stored_length", want.len, stored_length_o);
        compare_field("evicted", lct_pkg::LEN_W'(want.evicted), lct_pkg::LEN_W'(evicted_o));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Empty table, extreme keys and lengths, and a duplicate key at the reset capacity.
  task automatic test_fill_and_lookup();
    logic [lct_pkg::KEY_W-1:0] dup_key;
    dup_key = 64'h0123_4567_89AB_CDEF;
    send_word(lct_pkg::OP_LOOKUP, '0, '1);
    send_word(lct_pkg::OP_INSERT, '0, '0);
    send_word(lct_pkg::OP_INSERT, '1, '1);
    send_word(lct_pkg::OP_INSERT, dup_key, 32'h5A5A_5A5A);
    send_word(lct_pkg::OP_INSERT, dup_key, 32'hA5A5_A5A5);
    send_word(lct_pkg::OP_LOOKUP, dup_key, '0);
    send_word(lct_pkg::OP_LOOKUP, '1, '0);
    send_word(lct_pkg::OP_LOOKUP, '0, '0);
    send_word(lct_pkg::OP_LOOKUP, '0, '1);
    send_word(lct_pkg::OP_LOOKUP, 64'hFEDC_BA98_7654_3210, '0);
  endtask

  // Capacity below the fill level, zero, above the depth, and both ends of the range.
  task automatic test_capacity_edges();
    write_capacity(8'd2);
    send_word(lct_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF, '0);
    send_word(lct_pkg::OP_LOOKUP, '1, '0);
    send_word(lct_pkg::OP_INSERT, 64'h1111_2222_3333_4444, 32'h0000_0001);
    send_word(lct_pkg::OP_INSERT, 64'h5555_6666_7777_8888, 32'h8000_0000);
    write_capacity(8'd0);
    send_word(lct_pkg::OP_INSERT, 64'h9999_AAAA_BBBB_CCCC, 32'h1234_5678);
    send_word(lct_pkg::OP_LOOKUP, 64'h9999_AAAA_BBBB_CCCC, '0);
    write_capacity(8'd1);
    send_word(lct_pkg::OP_INSERT, 64'hDDDD_EEEE_FFFF_0000, 32'hFFFF_0000);
    write_capacity(8'hFF);
    send_word(lct_pkg::OP_INSERT, 64'h0F0F_0F0F_F0F0_F0F0, 32'h0000_FFFF);
    send_word(lct_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF, '0);
    write_capacity(8'd128);
    send_word(lct_pkg::OP_LOOKUP, 64'h0F0F_0F0F_F0F0_F0F0, '0);
  endtask

  // One random command word, mostly lookups, many of stored keys so that counts build up.
  task automatic send_random_item();
    lct_pkg::op_e              op;
    logic [lct_pkg::KEY_W-1:0] key;
    logic [lct_pkg::LEN_W-1:0] len;
    int                        span;
    int                        hot;
    span = (shadow_filled < live_capacity()) ? shadow_filled : live_capacity();
    key = {$urandom(), $urandom()};
    len = ($urandom_range(0, 9) == 0) ? {lct_pkg::LEN_W{1'($urandom_range(0, 1))}}
                                      : $urandom();
    if ($urandom_range(0, 99) < 40) begin
      op = lct_pkg::OP_INSERT;
      case ($urandom_range(0, 9))
        0: if (shadow_filled > 0) key = shadow_keys[$urandom_range(0, shadow_filled - 1)];
        1: key = {lct_pkg::KEY_W{1'($urandom_range(0, 1))}};
        default: ;
      endcase
    end else begin
      op = lct_pkg::OP_LOOKUP;
      case ($urandom_range(0, 9))
        0, 1, 2: if (span > 0) key = shadow_keys[$urandom_range(0, span - 1)];
        3, 4, 5: if (span > 0) begin
          // A few hot entries collect most of the hits.
          hot = (span > 4) ? 4 : span;
          key = shadow_keys[$urandom_range(0, hot - 1)];
        end
        6: if (shadow_filled > span) key = shadow_keys[$urandom_range(span, shadow_filled - 1)];
        default: ;
      endcase
    end
    send_word(op, key, len);
  endtask

  // Random traffic in segments, each under a fresh capacity setting.
  task automatic test_random_traffic(int idle_pct, int n_items);
    int                        sent;
    int                        seg_len;
    logic [lct_pkg::CNT_W-1:0] cap_val;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: cap_val = lct_pkg::CNT_W'($urandom_range(1, 12));
        3, 4:    cap_val = 8'd128;
        5:       cap_val = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'd0;
        6:       cap_val = lct_pkg::CNT_W'($urandom_range(129, 255));
        default: cap_val = lct_pkg::CNT_W'($urandom_range(1, 128));
      endcase
      write_capacity(cap_val);
      seg_len = $urandom_range(20, 60);
      repeat (seg_len) send_random_item();
      sent += seg_len;
    end
  endtask

  initial begin
    foreach (shadow_uses[i]) shadow_uses[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 28;
    test_fill_and_lookup();
    test_capacity_edges();
    test_random_traffic(28, 230);
    test_random_traffic(56, 230);
    test_random_traffic(0, 240);
    // Let the last result words arrive before deciding.
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
